// ===== src/tts_pkg.sv =====
// Shared types, widths and state codes of the triangle tangent-space block.
package tts_pkg;

	localparam int POS_W         = 32;
	localparam int UV_W          = 20;
	localparam int EDGE_W        = POS_W + 1;
	localparam int UVD_W         = UV_W + 1;
	localparam int PROD_W        = EDGE_W + UVD_W;
	localparam int ACC_W         = PROD_W + 1;
	localparam int DET_W         = 2 * UVD_W + 1;
	localparam int OUT_W         = 32;
	localparam int FRAC_BITS_DEF = 16;
	localparam int Q_DEPTH_DEF   = 2;
	localparam int MUL_STEPS     = 14;
	localparam int NUM_ACC       = 7;

	typedef struct packed {
		logic signed [EDGE_W-1:0] d1x;
		logic signed [EDGE_W-1:0] d1y;
		logic signed [EDGE_W-1:0] d1z;
		logic signed [EDGE_W-1:0] d2x;
		logic signed [EDGE_W-1:0] d2y;
		logic signed [EDGE_W-1:0] d2z;
		logic signed [UVD_W-1:0]  du1;
		logic signed [UVD_W-1:0]  dv1;
		logic signed [UVD_W-1:0]  du2;
		logic signed [UVD_W-1:0]  dv2;
	} tri_t;

	typedef enum logic [1:0] {
		PH_V0 = 2'd0,
		PH_V1 = 2'd1,
		PH_V2 = 2'd2
	} phase_t;

	typedef enum logic [2:0] {
		BK_IDLE  = 3'd0,
		BK_MUL   = 3'd1,
		BK_DRAIN = 3'd2,
		BK_LOAD  = 3'd3,
		BK_DIV   = 3'd4,
		BK_SAT   = 3'd5,
		BK_DONE  = 3'd6
	} back_state_t;

endpackage

// ===== src/tts_front.sv =====
// Front end: holds the first two vertices and forms the triangle edges.
module tts_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	output logic                              full,
	input  logic signed [tts_pkg::POS_W-1:0]  pos_x,
	input  logic signed [tts_pkg::POS_W-1:0]  pos_y,
	input  logic signed [tts_pkg::POS_W-1:0]  pos_z,
	input  logic signed [tts_pkg::UV_W-1:0]   tex_u,
	input  logic signed [tts_pkg::UV_W-1:0]   tex_v,
	input  logic                              q_full,
	output logic                              q_push,
	output tts_pkg::tri_t                     q_data
);

	tts_pkg::phase_t phase_q, phase_d;
	logic signed [tts_pkg::POS_W-1:0] p0x_q, p0y_q, p0z_q, p1x_q, p1y_q, p1z_q;
	logic signed [tts_pkg::UV_W-1:0]  u0_q, v0_q, u1_q, v1_q;
	logic                             accept;
	logic                             third;

	assign third  = (phase_q == tts_pkg::PH_V2);
	assign full   = third && q_full;
	assign accept = push && !full;
	assign q_push = accept && third;

	always_comb begin
		phase_d = phase_q;
		if (accept) begin
			unique case (phase_q)
				tts_pkg::PH_V0: phase_d = tts_pkg::PH_V1;
				tts_pkg::PH_V1: phase_d = tts_pkg::PH_V2;
				default:        phase_d = tts_pkg::PH_V0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= tts_pkg::PH_V0;
		end else begin
			phase_q <= phase_d;
		end
	end

	// A stray phase code three acts as the first vertex.
	always_ff @(posedge clk) begin
		if (accept && phase_q != tts_pkg::PH_V1 && !third) begin
			p0x_q <= pos_x;
			p0y_q <= pos_y;
			p0z_q <= pos_z;
			u0_q  <= tex_u;
			v0_q  <= tex_v;
		end
		if (accept && phase_q == tts_pkg::PH_V1) begin
			p1x_q <= pos_x;
			p1y_q <= pos_y;
			p1z_q <= pos_z;
			u1_q  <= tex_u;
			v1_q  <= tex_v;
		end
	end

	always_comb begin
		q_data.d1x = tts_pkg::EDGE_W'(p1x_q) - tts_pkg::EDGE_W'(p0x_q);
		q_data.d1y = tts_pkg::EDGE_W'(p1y_q) - tts_pkg::EDGE_W'(p0y_q);
		q_data.d1z = tts_pkg::EDGE_W'(p1z_q) - tts_pkg::EDGE_W'(p0z_q);
		q_data.d2x = tts_pkg::EDGE_W'(pos_x) - tts_pkg::EDGE_W'(p0x_q);
		q_data.d2y = tts_pkg::EDGE_W'(pos_y) - tts_pkg::EDGE_W'(p0y_q);
		q_data.d2z = tts_pkg::EDGE_W'(pos_z) - tts_pkg::EDGE_W'(p0z_q);
		q_data.du1 = tts_pkg::UVD_W'(u1_q) - tts_pkg::UVD_W'(u0_q);
		q_data.dv1 = tts_pkg::UVD_W'(v1_q) - tts_pkg::UVD_W'(v0_q);
		q_data.du2 = tts_pkg::UVD_W'(tex_u) - tts_pkg::UVD_W'(u0_q);
		q_data.dv2 = tts_pkg::UVD_W'(tex_v) - tts_pkg::UVD_W'(v0_q);
	end

endmodule

// ===== src/tts_queue.sv =====
// Small queue of triangle edge sets between the front and back ends.
module tts_queue #(
	parameter int DEPTH = tts_pkg::Q_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr,
	input  tts_pkg::tri_t wr_data,
	output logic          q_full,
	input  logic          rd,
	output logic          q_valid,
	output tts_pkg::tri_t rd_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	tts_pkg::tri_t    mem_q [DEPTH];
	logic [PTR_W-1:0] wp_q, rp_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_wr, do_rd;

	assign q_full  = (cnt_q == CNT_W'(DEPTH));
	assign q_valid = (cnt_q != '0);
	assign do_wr   = wr && !q_full;
	assign do_rd   = rd && q_valid;
	assign rd_data = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wp_q <= (wp_q == PTR_W'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (do_rd) begin
				rp_q <= (rp_q == PTR_W'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wp_q] <= wr_data;
		end
	end

endmodule

// ===== src/tts_back.sv =====
// Back end: shared multiplier, determinant, serial divider and saturation.
module tts_back #(
	parameter int FRAC_BITS = tts_pkg::FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              q_valid,
	input  tts_pkg::tri_t                     q_data,
	output logic                              q_pop,
	output logic                              empty,
	input  logic                              pop,
	output logic signed [tts_pkg::OUT_W-1:0]  tangent_x,
	output logic signed [tts_pkg::OUT_W-1:0]  tangent_y,
	output logic signed [tts_pkg::OUT_W-1:0]  tangent_z,
	output logic signed [tts_pkg::OUT_W-1:0]  bitangent_x,
	output logic signed [tts_pkg::OUT_W-1:0]  bitangent_y,
	output logic signed [tts_pkg::OUT_W-1:0]  bitangent_z,
	output logic                              degenerate
);

	localparam int ACC_W  = tts_pkg::ACC_W;
	localparam int DET_W  = tts_pkg::DET_W;
	localparam int OUT_W  = tts_pkg::OUT_W;
	localparam int DIVD_W = ACC_W + FRAC_BITS;
	localparam int CNT_W  = $clog2(DIVD_W + 1);

	tts_pkg::back_state_t state_q, state_d;
	tts_pkg::tri_t        tri_q;
	logic [3:0]           step_q;
	logic [2:0]           comp_q;

	logic signed [tts_pkg::EDGE_W-1:0] op_a;
	logic signed [tts_pkg::UVD_W-1:0]  op_b;
	logic [2:0]                        op_dest;
	logic                              op_sub;

	logic signed [tts_pkg::PROD_W-1:0] prod_s1;
	logic                              pv_s1;
	logic [2:0]                        pdest_s1;
	logic                              psub_s1;
	logic signed [ACC_W-1:0]           acc_q [tts_pkg::NUM_ACC];

	logic [DIVD_W-1:0] divd_q;
	logic [DET_W:0]    rem_q;
	logic [DET_W-1:0]  den_q;
	logic [OUT_W:0]    quo_q;
	logic              ovf_q;
	logic              neg_q;
	logic [CNT_W-1:0]  cnt_q;

	logic [OUT_W-1:0]  res_q [6];
	logic              deg_q;

	logic              out_valid_q;
	logic [OUT_W-1:0]  out_q [6];
	logic              out_deg_q;

	logic signed [ACC_W-1:0] num_sel;
	logic [ACC_W-1:0]        num_mag;
	logic [ACC_W-1:0]        det_mag;
	logic                    det_zero;
	logic [DET_W:0]          rem_sh;
	logic                    ge;
	logic                    big;
	logic [OUT_W-1:0]        sat_val;
	logic                    out_free;

	assign det_zero = (acc_q[0] == '0);
	assign num_sel  = acc_q[comp_q];
	assign num_mag  = num_sel[ACC_W-1] ? ACC_W'(-num_sel) : ACC_W'(num_sel);
	assign det_mag  = acc_q[0][ACC_W-1] ? ACC_W'(-acc_q[0]) : ACC_W'(acc_q[0]);
	assign out_free = !out_valid_q || pop;
	assign q_pop    = (state_q == tts_pkg::BK_IDLE) && q_valid;

	// Product schedule: two terms of the determinant, then two terms for
	// each tangent and each bitangent component.
	always_comb begin
		op_a    = '0;
		op_b    = '0;
		op_dest = '0;
		op_sub  = 1'b0;
		unique case (step_q)
			4'd0:  begin op_a = 33'(tri_q.du1); op_b = tri_q.dv2; op_dest = 3'd0; end
			4'd1:  begin op_a = 33'(tri_q.dv1); op_b = tri_q.du2; op_dest = 3'd0; op_sub = 1'b1; end
			4'd2:  begin op_a = tri_q.d1x; op_b = tri_q.dv2; op_dest = 3'd1; end
			4'd3:  begin op_a = tri_q.d2x; op_b = tri_q.dv1; op_dest = 3'd1; op_sub = 1'b1; end
			4'd4:  begin op_a = tri_q.d2x; op_b = tri_q.du1; op_dest = 3'd4; end
			4'd5:  begin op_a = tri_q.d1x; op_b = tri_q.du2; op_dest = 3'd4; op_sub = 1'b1; end
			4'd6:  begin op_a = tri_q.d1y; op_b = tri_q.dv2; op_dest = 3'd2; end
			4'd7:  begin op_a = tri_q.d2y; op_b = tri_q.dv1; op_dest = 3'd2; op_sub = 1'b1; end
			4'd8:  begin op_a = tri_q.d2y; op_b = tri_q.du1; op_dest = 3'd5; end
			4'd9:  begin op_a = tri_q.d1y; op_b = tri_q.du2; op_dest = 3'd5; op_sub = 1'b1; end
			4'd10: begin op_a = tri_q.d1z; op_b = tri_q.dv2; op_dest = 3'd3; end
			4'd11: begin op_a = tri_q.d2z; op_b = tri_q.dv1; op_dest = 3'd3; op_sub = 1'b1; end
			4'd12: begin op_a = tri_q.d2z; op_b = tri_q.du1; op_dest = 3'd6; end
			4'd13: begin op_a = tri_q.d1z; op_b = tri_q.du2; op_dest = 3'd6; op_sub = 1'b1; end
			default: ;
		endcase
	end

	// One restoring division step per cycle.
	assign rem_sh = {rem_q[DET_W-1:0], divd_q[DIVD_W-1]};
	assign ge     = (rem_sh >= {1'b0, den_q});

	always_comb begin
		big = ovf_q || quo_q[OUT_W];
		if (!neg_q) begin
			sat_val = (big || quo_q[OUT_W-1]) ? {1'b0, {(OUT_W-1){1'b1}}} : quo_q[OUT_W-1:0];
		end else if (big || (quo_q[OUT_W-1] && quo_q[OUT_W-2:0] != '0)) begin
			sat_val = {1'b1, {(OUT_W-1){1'b0}}};
		end else begin
			sat_val = OUT_W'(-quo_q[OUT_W-1:0]);
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tts_pkg::BK_IDLE:  if (q_valid) state_d = tts_pkg::BK_MUL;
			tts_pkg::BK_MUL:   if (step_q == 4'(tts_pkg::MUL_STEPS - 1)) state_d = tts_pkg::BK_DRAIN;
			tts_pkg::BK_DRAIN: state_d = det_zero ? tts_pkg::BK_DONE : tts_pkg::BK_LOAD;
			tts_pkg::BK_LOAD:  state_d = tts_pkg::BK_DIV;
			tts_pkg::BK_DIV:   if (cnt_q == CNT_W'(DIVD_W - 1)) state_d = tts_pkg::BK_SAT;
			tts_pkg::BK_SAT:   state_d = (comp_q == 3'd6) ? tts_pkg::BK_DONE : tts_pkg::BK_LOAD;
			tts_pkg::BK_DONE:  if (out_free) state_d = tts_pkg::BK_IDLE;
			default:           state_d = tts_pkg::BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tts_pkg::BK_IDLE;
			step_q      <= '0;
			comp_q      <= '0;
			pv_s1       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			pv_s1   <= (state_q == tts_pkg::BK_MUL);
			if (state_q == tts_pkg::BK_IDLE) begin
				step_q <= '0;
				comp_q <= 3'd1;
			end else if (state_q == tts_pkg::BK_MUL) begin
				step_q <= step_q + 1'b1;
			end else if (state_q == tts_pkg::BK_SAT) begin
				comp_q <= comp_q + 1'b1;
			end
			if (state_q == tts_pkg::BK_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			tri_q <= q_data;
		end
		prod_s1  <= op_a * op_b;
		pdest_s1 <= op_dest;
		psub_s1  <= op_sub;
		if (pv_s1) begin
			acc_q[pdest_s1] <= psub_s1 ? acc_q[pdest_s1] - ACC_W'(prod_s1) : ACC_W'(prod_s1);
		end
		if (state_q == tts_pkg::BK_DRAIN) begin
			deg_q <= det_zero;
		end
		if (state_q == tts_pkg::BK_LOAD) begin
			divd_q <= {num_mag, {FRAC_BITS{1'b0}}};
			rem_q  <= '0;
			den_q  <= det_mag[DET_W-1:0];
			quo_q  <= '0;
			ovf_q  <= 1'b0;
			neg_q  <= num_sel[ACC_W-1] ^ acc_q[0][ACC_W-1];
			cnt_q  <= '0;
		end else if (state_q == tts_pkg::BK_DIV) begin
			divd_q <= {divd_q[DIVD_W-2:0], 1'b0};
			rem_q  <= ge ? rem_sh - {1'b0, den_q} : rem_sh;
			quo_q  <= {quo_q[OUT_W-1:0], ge};
			ovf_q  <= ovf_q || quo_q[OUT_W];
			cnt_q  <= cnt_q + 1'b1;
		end
		if (state_q == tts_pkg::BK_SAT) begin
			res_q[comp_q - 3'd1] <= sat_val;
		end
		if (state_q == tts_pkg::BK_DONE && out_free) begin
			for (int i = 0; i < 6; i++) begin
				out_q[i] <= deg_q ? '0 : res_q[i];
			end
			out_deg_q <= deg_q;
		end
	end

	assign empty       = !out_valid_q;
	assign tangent_x   = out_q[0];
	assign tangent_y   = out_q[1];
	assign tangent_z   = out_q[2];
	assign bitangent_x = out_q[3];
	assign bitangent_y = out_q[4];
	assign bitangent_z = out_q[5];
	assign degenerate  = out_deg_q;

	a_deg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_deg_q) |-> (out_q[0] == '0 && out_q[3] == '0 && out_q[5] == '0))
		else $error("degenerate result carries nonzero vectors");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tts_pkg::BK_DIV) |-> (den_q != '0))
		else $error("division started with a zero determinant");

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tts_pkg::BK_MUL) |-> (step_q < 4'(tts_pkg::MUL_STEPS)))
		else $error("product schedule ran past its end");

	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> (state_q == tts_pkg::BK_MUL && step_q == '0))
		else $error("triangle taken from queue without starting products");

endmodule

// ===== src/triangle_tangent_space.sv =====
// Top level of the per-triangle tangent and bitangent block.
//
// Vertices enter one beat at a time through a queue-like port: a beat is
// taken when push is high and full is low. Every third vertex closes a
// triangle; the first two are only held. Results leave through a second
// queue-like port: while empty is low the oldest result is on the output
// ports, and it is taken when pop is high.
// The front end takes the first two vertices of a triangle whenever push is
// high and the third as soon as the edge queue has room, so full only rises on a
// third vertex while the queue is full. The back end works on one triangle
// at a time: 14 product steps on a single shared multiplier and a drain
// step, then six serial divisions of (55 + FRAC_BITS) steps, each with a
// load and a saturation step, and a last step to hand the result over. The
// divider produces one quotient bit per cycle. A zero determinant skips the
// divisions. Reset clears the vertex phase, the queue and the output slot.
// When the receiver does not pop, the back end finishes the next triangle
// and waits; the edge queue then fills and full holds the third vertex back.
module triangle_tangent_space #(
	parameter int FRAC_BITS = tts_pkg::FRAC_BITS_DEF,
	parameter int Q_DEPTH   = tts_pkg::Q_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	output logic                              full,
	input  logic signed [tts_pkg::POS_W-1:0]  pos_x,
	input  logic signed [tts_pkg::POS_W-1:0]  pos_y,
	input  logic signed [tts_pkg::POS_W-1:0]  pos_z,
	input  logic signed [tts_pkg::UV_W-1:0]   tex_u,
	input  logic signed [tts_pkg::UV_W-1:0]   tex_v,
	output logic                              empty,
	input  logic                              pop,
	output logic signed [tts_pkg::OUT_W-1:0]  tangent_x,
	output logic signed [tts_pkg::OUT_W-1:0]  tangent_y,
	output logic signed [tts_pkg::OUT_W-1:0]  tangent_z,
	output logic signed [tts_pkg::OUT_W-1:0]  bitangent_x,
	output logic signed [tts_pkg::OUT_W-1:0]  bitangent_y,
	output logic signed [tts_pkg::OUT_W-1:0]  bitangent_z,
	output logic                              degenerate
);

	// Edge sets travel from the front end to the back end through the queue.
	logic          q_push, q_full, q_pop, q_valid;
	tts_pkg::tri_t q_wdata, q_rdata;

	tts_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.pos_x  (pos_x),
		.pos_y  (pos_y),
		.pos_z  (pos_z),
		.tex_u  (tex_u),
		.tex_v  (tex_v),
		.q_full (q_full),
		.q_push (q_push),
		.q_data (q_wdata)
	);

	tts_queue #(
		.DEPTH (Q_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (q_push),
		.wr_data (q_wdata),
		.q_full  (q_full),
		.rd      (q_pop),
		.q_valid (q_valid),
		.rd_data (q_rdata)
	);

	tts_back #(
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_data      (q_rdata),
		.q_pop       (q_pop),
		.empty       (empty),
		.pop         (pop),
		.tangent_x   (tangent_x),
		.tangent_y   (tangent_y),
		.tangent_z   (tangent_z),
		.bitangent_x (bitangent_x),
		.bitangent_y (bitangent_y),
		.bitangent_z (bitangent_z),
		.degenerate  (degenerate)
	);

endmodule
